// ----- design/sstl_pkg.sv -----
// Package for the servo speed table linearizer: sizes, shipped calibration
// tables, controller state type and controller/datapath command structs.
`timescale 1ns / 1ps
package sstl_pkg;

	localparam int TableEntries = 41;
	localparam int IdxW = $clog2(TableEntries);
	localparam int PulseCenter = 1500;
	localparam int OffsetFirst = -200;
	localparam int OffsetStep = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CONVERT = 1'b1;
	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD0,
		ST_RDLAST,
		ST_CHKLAST,
		ST_RDSCAN,
		ST_SCAN,
		ST_DIV,
		ST_FIX,
		ST_NEXTW,
		ST_OUT
	} sstl_state_t;

	typedef struct packed {
		logic            init;
		logic            load;
		logic            wr;
		logic            rd;
		logic [IdxW-1:0] rd_idx;
		logic            sel_right;
		logic            cap_first;
		logic            cap_last;
		logic            scan_step;
		logic            div_start;
		logic            div_step;
		logic            fix;
		logic            out_load;
	} sstl_cmd_t;

	typedef struct packed {
		logic below;
		logic above;
		logic interp;
		logic div_done;
	} sstl_sts_t;

	function automatic logic signed [15:0] shipped(input logic side, input int k);
		logic signed [15:0] l [0:40];
		logic signed [15:0] r [0:40];
		l = '{-16'sd2867, -16'sd2867, -16'sd2867, -16'sd2867, -16'sd2949, -16'sd2867,
			-16'sd2949, -16'sd2867, -16'sd2867, -16'sd2826, -16'sd2744, -16'sd2703,
			-16'sd2580, -16'sd2499, -16'sd2294, -16'sd1966, -16'sd1597, -16'sd1147,
			-16'sd696, -16'sd328, 16'sd0, 16'sd123, 16'sd492, 16'sd1024, 16'sd1393,
			16'sd1802, 16'sd2048, 16'sd2376, 16'sd2580, 16'sd2621, 16'sd2703, 16'sd2744,
			16'sd2826, 16'sd2826, 16'sd2867, 16'sd2867, 16'sd2949, 16'sd2867, 16'sd2867,
			16'sd2949, 16'sd2867};
		r = '{-16'sd2867, -16'sd2867, -16'sd2867, -16'sd2867, -16'sd2867, -16'sd2867,
			-16'sd2867, -16'sd2867, -16'sd2826, -16'sd2826, -16'sd2744, -16'sd2703,
			-16'sd2580, -16'sd2499, -16'sd2294, -16'sd1966, -16'sd1597, -16'sd1229,
			-16'sd778, -16'sd328, 16'sd0, 16'sd328, 16'sd696, 16'sd1147, 16'sd1516,
			16'sd1966, 16'sd2253, 16'sd2499, 16'sd2621, 16'sd2744, 16'sd2744, 16'sd2826,
			16'sd2826, 16'sd2867, 16'sd2867, 16'sd2867, 16'sd2867, 16'sd2867, 16'sd2867,
			16'sd2867, 16'sd2867};
		if (k > 40) begin
			return 16'sd0;
		end
		return side ? r[k] : l[k];
	endfunction

endpackage

// ----- design/sstl_stream_if.sv -----
// Valid/ready stream interface used for the input and result channels.
// Depends on sstl_pkg for nothing but is compiled after it.
`timescale 1ns / 1ps
interface sstl_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic               side;
	logic [5:0]         entry_index;
	logic signed [15:0] entry_value;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	modport source (output valid, op, side, entry_index, entry_value, left_speed,
		right_speed, input ready);
	modport sink (input valid, op, side, entry_index, entry_value, left_speed,
		right_speed, output ready);
endinterface

interface sstl_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] left_pulse_us;
	logic [10:0] right_pulse_us;
	modport source (output valid, left_pulse_us, right_pulse_us, input ready);
	modport sink (input valid, left_pulse_us, right_pulse_us, output ready);
endinterface

// ----- design/sstl_ctrl.sv -----
// Controller state machine: sequences table reads, the segment scan and the
// serial division for each wheel. Depends on sstl_pkg.
`timescale 1ns / 1ps
module sstl_ctrl import sstl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_op,
	input  logic      out_busy,
	input  sstl_sts_t sts,
	output sstl_cmd_t cmd
);
	sstl_state_t state_q, state_d;
	logic [IdxW-1:0] i_q, i_d;
	logic side_q, side_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			i_q <= '0;
			side_q <= SIDE_LEFT;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			side_q <= side_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		side_d = side_q;
		cmd = '0;
		cmd.sel_right = side_q;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				// One entry of both tables is loaded with its shipped value per cycle.
				cmd.init = 1'b1;
				cmd.rd_idx = i_q;
				if (i_q == IdxW'(TableEntries - 1)) begin
					i_d = '0;
					state_d = ST_IDLE;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_CONVERT) begin
						cmd.load = 1'b1;
						side_d = SIDE_LEFT;
						state_d = ST_RD0;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_RD0: begin
				cmd.rd = 1'b1;
				cmd.rd_idx = '0;
				state_d = ST_RDLAST;
			end
			ST_RDLAST: begin
				cmd.cap_first = 1'b1;
				cmd.rd = 1'b1;
				cmd.rd_idx = IdxW'(TableEntries - 1);
				state_d = ST_CHKLAST;
			end
			ST_CHKLAST: begin
				cmd.cap_last = 1'b1;
				i_d = IdxW'(1);
				if (sts.below || sts.above) begin
					state_d = ST_NEXTW;
				end else begin
					cmd.rd = 1'b1;
					cmd.rd_idx = IdxW'(1);
					state_d = ST_SCAN;
				end
			end
			ST_RDSCAN: begin
				cmd.rd = 1'b1;
				cmd.rd_idx = i_q;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.interp) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else if (i_q == IdxW'(TableEntries - 1)) begin
					state_d = ST_NEXTW;
				end else begin
					i_d = i_q + 1'b1;
					state_d = ST_RDSCAN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				if (i_q == IdxW'(TableEntries - 1)) begin
					state_d = ST_NEXTW;
				end else begin
					i_d = i_q + 1'b1;
					state_d = ST_RDSCAN;
				end
			end
			ST_NEXTW: begin
				if (side_q == SIDE_RIGHT) begin
					state_d = ST_OUT;
				end else begin
					side_d = SIDE_RIGHT;
					state_d = ST_RD0;
				end
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- design/sstl_dp.sv -----
// Datapath: both calibration tables, compare logic, offset register and a
// short restoring divider, plus the generic RAM that holds each table.
// Depends on sstl_pkg.
`timescale 1ns / 1ps
module sstl_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata_q
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

module sstl_dp import sstl_pkg::*; (
	input  logic               clk,
	input  sstl_cmd_t          cmd,
	output sstl_sts_t          sts,
	input  logic               in_side,
	input  logic [5:0]         in_index,
	input  logic signed [15:0] in_value,
	input  logic signed [15:0] in_left,
	input  logic signed [15:0] in_right,
	output logic [10:0]        pulse_l,
	output logic [10:0]        pulse_r
);
	logic signed [15:0] rd_l, rd_r, rd_data;
	logic signed [15:0] prev_q, first_q;
	logic signed [15:0] xl_q, xr_q;
	logic signed [9:0]  off_q, offl_q;
	logic [IdxW-1:0]    seg_q, idx_q;
	logic [19:0]        rem_q, num_x, den_sh;
	logic [16:0]        den_q;
	logic [3:0]         quo_q;
	logic [2:0]         dcnt_q;
	logic [1:0]         qbit;
	logic signed [15:0] x;
	logic signed [17:0] diff_x, diff_t;
	logic signed [9:0]  seg_base;
	logic               wr_ok, we_l, we_r;
	logic [IdxW-1:0]    waddr;
	logic signed [15:0] wdata_l, wdata_r;

	// The init pass after reset writes the shipped calibration through the
	// normal write port, one entry of both tables per cycle.
	assign wr_ok = cmd.wr && (in_index < 6'(TableEntries));
	assign waddr = cmd.init ? cmd.rd_idx : in_index[IdxW-1:0];
	assign we_l = cmd.init || (wr_ok && in_side == SIDE_LEFT);
	assign we_r = cmd.init || (wr_ok && in_side == SIDE_RIGHT);
	assign wdata_l = cmd.init ? shipped(SIDE_LEFT, int'(cmd.rd_idx)) : in_value;
	assign wdata_r = cmd.init ? shipped(SIDE_RIGHT, int'(cmd.rd_idx)) : in_value;

	sstl_ram #(.Width(16), .Depth(TableEntries)) u_tab_l (
		.clk(clk), .we(we_l), .waddr(waddr), .wdata(wdata_l), .re(cmd.rd),
		.raddr(cmd.rd_idx), .rdata_q(rd_l)
	);

	sstl_ram #(.Width(16), .Depth(TableEntries)) u_tab_r (
		.clk(clk), .we(we_r), .waddr(waddr), .wdata(wdata_r), .re(cmd.rd),
		.raddr(cmd.rd_idx), .rdata_q(rd_r)
	);

	assign rd_data = cmd.sel_right ? rd_r : rd_l;
	assign x = cmd.sel_right ? xr_q : xl_q;

	assign diff_x = 18'(x) - 18'(prev_q);
	assign diff_t = 18'(rd_data) - 18'(prev_q);
	assign num_x = {3'b000, diff_x[16:0]};
	assign qbit = dcnt_q[1:0] - 2'd1;
	assign den_sh = {3'b000, den_q} << qbit;
	assign seg_base = 10'(OffsetFirst) + 10'(OffsetStep) * $signed({1'b0, seg_q})
		- 10'(OffsetStep);

	assign sts.below = (x <= first_q);
	assign sts.above = (x >= rd_data);
	assign sts.interp = (x > prev_q) && (x < rd_data);
	assign sts.div_done = (dcnt_q == 3'd1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xl_q <= in_left;
			xr_q <= in_right;
		end
		if (cmd.rd) begin
			idx_q <= cmd.rd_idx;
		end
		if (cmd.cap_first) begin
			first_q <= rd_data;
			prev_q <= rd_data;
		end
		if (cmd.cap_last) begin
			off_q <= 10'sd0;
			if (sts.below) begin
				off_q <= 10'(OffsetFirst);
			end else if (sts.above) begin
				off_q <= 10'(OffsetFirst + OffsetStep * (TableEntries - 1));
			end
		end
		if (cmd.scan_step) begin
			prev_q <= rd_data;
			seg_q <= idx_q;
			if (x == rd_data) begin
				off_q <= 10'(OffsetFirst) + 10'(OffsetStep) * $signed({1'b0, idx_q});
			end
		end
		// The fraction 10*(x-lo)/(hi-lo) lies below 10, so four quotient
		// bits are enough.
		if (cmd.div_start) begin
			rem_q <= (num_x << 3) + (num_x << 1);
			den_q <= diff_t[16:0];
			quo_q <= '0;
			dcnt_q <= 3'd4;
		end else if (cmd.div_step) begin
			if (rem_q >= den_sh) begin
				rem_q <= rem_q - den_sh;
				quo_q[qbit] <= 1'b1;
			end
			dcnt_q <= dcnt_q - 3'd1;
		end
		if (cmd.fix) begin
			// base + q, rounding the total toward zero for negative bases
			off_q <= seg_base + $signed({6'b0, quo_q})
				+ ((seg_base < 0 && rem_q != '0) ? 10'sd1 : 10'sd0);
		end
		if (cmd.out_load) begin
			pulse_r <= 11'(PulseCenter) - 11'(off_q);
			pulse_l <= 11'(PulseCenter) + 11'(offl_q);
		end
		if (cmd.sel_right == SIDE_LEFT && !cmd.out_load) begin
			offl_q <= off_q;
		end
	end
endmodule

// ----- design/servo_speed_table_linearizer_top.sv -----
// Top level of the servo speed table linearizer.
// After reset the input is held off while both tables load. A write item
// leaves the block idle. Per wheel, a convert item reads the first and last
// entries for a range check; in range all 40 segments are scanned, with a
// serial division per interpolating segment (at most one on a monotonic
// table). One item at a time; an async reset reloads the shipped tables.
`timescale 1ns / 1ps
module servo_speed_table_linearizer_top import sstl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sstl_in_if.sink    in_ch,
	sstl_out_if.source out_ch
);
	sstl_cmd_t cmd;
	sstl_sts_t sts;
	logic      out_valid_q;
	logic [10:0] pl, pr;

	sstl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_op(in_ch.op), .out_busy(out_valid_q && !out_ch.ready), .sts(sts), .cmd(cmd)
	);

	sstl_dp u_dp (
		.clk(clk), .cmd(cmd), .sts(sts), .in_side(in_ch.side),
		.in_index(in_ch.entry_index), .in_value(in_ch.entry_value),
		.in_left(in_ch.left_speed), .in_right(in_ch.right_speed),
		.pulse_l(pl), .pulse_r(pr)
	);

	// The result register holds until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.left_pulse_us = pl;
	assign out_ch.right_pulse_us = pr;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !cmd.out_load)
		else $error("result overwritten before it was taken");
	a_write_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> in_ch.ready)
		else $error("table write outside idle");
endmodule
